// File: src/btc_pkg.sv
// types, constants and tables shared by the balanced ternary converter
// no dependencies; imported by every module of the converter
`default_nettype none

package btc_pkg;

    // trit positions held for one conversion
    localparam int MAX_TRITS = 21;
    localparam int POS_W     = $clog2(MAX_TRITS);
    // remainder word: wide enough for 3^MAX_TRITS
    localparam int REM_W     = 34;
    localparam int QUEUE_DEPTH = 2;

    // symbol codes
    localparam logic [1:0] SYM_ZERO  = 2'd0;
    localparam logic [1:0] SYM_PLUS  = 2'd1;
    localparam logic [1:0] SYM_MINUS = 2'd2;
    localparam logic [1:0] SYM_POINT = 2'd3;

    typedef logic [MAX_TRITS-1:0][REM_W-1:0] pow_tab_t;
    typedef logic [MAX_TRITS-1:0][1:0]       trit_vec_t;
    typedef logic [POS_W-1:0]                pos_t;

    function automatic pow_tab_t pow3_table();
        pow_tab_t tab;
        logic [REM_W-1:0] v;
        v = 1;
        for (int i = 0; i < MAX_TRITS; i++) begin
            tab[i] = v;
            v = v * 3;
        end
        return tab;
    endfunction

    function automatic logic [REM_W:0] pow3_full();
        logic [REM_W:0] v;
        v = 1;
        for (int i = 0; i < MAX_TRITS; i++) begin
            v = v * 3;
        end
        return v;
    endfunction

    localparam pow_tab_t POW3 = pow3_table();
    localparam logic [REM_W:0] POW3_ALL = pow3_full();
    // ternary all-ones word over every trit position
    localparam logic [REM_W-1:0] ONES_OFFSET = REM_W'((POW3_ALL - 1) / 2);

    typedef struct packed {
        logic signed [31:0] numerator;
        logic [30:0]        denominator;
    } btc_in_t;

    typedef struct packed {
        logic [1:0] symbol;
        logic       last;
    } btc_out_t;

    // one classified conversion handed from front to back
    typedef struct packed {
        trit_vec_t trits;
        pos_t      top;
        pos_t      fl;
        pos_t      mov;
        logic      zero;
    } btc_desc_t;

endpackage

`default_nettype wire

// File: src/balanced_ternary_converter.sv
// top level of the balanced ternary converter
// depends on btc_pkg, btc_front, btc_queue and btc_back
`default_nettype none

// A transaction is taken when start is high and busy is low. The front end
// handles each transaction as an accept step, one step per trit for the 21
// trit positions in its compare-and-subtract unit and a hand-off step, and a
// new transaction can be taken only after the hand-off. The back end emits
// between 1 and 22 symbols on result, one per cycle, each marked by
// result_valid, with result.last on the final symbol; it loads each
// conversion from a two-entry queue while idle. The receiver cannot stall;
// results are never held back by it. Busy also stays high while the queue
// is full.
module balanced_ternary_converter (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  btc_pkg::btc_in_t    operand,
    output logic                busy,
    output logic                result_valid,
    output btc_pkg::btc_out_t   result
);
    import btc_pkg::*;

    btc_desc_t wr_desc, rd_desc;
    logic      push, pop, full, empty;

    btc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (operand),
        .busy    (busy),
        .push    (push),
        .desc    (wr_desc),
        .full    (full)
    );

    btc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .rd_desc (rd_desc),
        .full    (full),
        .empty   (empty)
    );

    btc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (rd_desc),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: src/btc_front.sv
// front end: accepts a transaction, builds the balanced trits msb first
// and finds top, lowest nonzero trit and radix point; depends on btc_pkg
`default_nettype none

module btc_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  btc_pkg::btc_in_t     operand,
    output logic                 busy,
    output logic                 push,
    output btc_pkg::btc_desc_t   desc,
    input  wire                  full
);
    import btc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]       st_reg, st_next;
    logic [REM_W-1:0] rem_reg;
    logic [30:0]      den_reg;
    logic             neg_reg;
    pos_t             k_reg;
    trit_vec_t        trits_reg;
    pos_t             top_reg, fl_reg, mov_reg;
    logic             found_reg;

    logic [31:0]      mag;
    logic [REM_W-1:0] p1, p2, sub;
    logic             ge1, ge2, nonzero;
    logic [1:0]       code;

    assign mag = operand.numerator[31] ? (32'd0 - operand.numerator) : operand.numerator;
    assign p1  = POW3[k_reg];
    assign p2  = {p1[REM_W-2:0], 1'b0};
    assign ge2 = rem_reg >= p2;
    assign ge1 = rem_reg >= p1;
    assign sub = ge2 ? p2 : (ge1 ? p1 : '0);
    assign nonzero = ge2 || !ge1;

    always_comb
    begin
        if (ge2)
            code = neg_reg ? SYM_MINUS : SYM_PLUS;
        else if (ge1)
            code = SYM_ZERO;
        else
            code = neg_reg ? SYM_PLUS : SYM_MINUS;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (start) st_next = ST_CONV;
            ST_CONV: if (k_reg == '0) st_next = ST_PUSH;
            ST_PUSH: if (!full) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
        begin
            rem_reg   <= {{(REM_W-32){1'b0}}, mag} + ONES_OFFSET;
            den_reg   <= operand.denominator;
            neg_reg   <= operand.numerator[31];
            k_reg     <= pos_t'(MAX_TRITS - 1);
            found_reg <= 1'b0;
            mov_reg   <= '0;
            top_reg   <= '0;
            fl_reg    <= '0;
        end
        else if (st_reg == ST_CONV)
        begin
            rem_reg   <= rem_reg - sub;
            trits_reg <= {trits_reg[MAX_TRITS-2:0], code};
            // mov counts thresholds 2*3^k that the denominator reaches
            if ({{(REM_W-31){1'b0}}, den_reg} >= p2)
                mov_reg <= mov_reg + pos_t'(1);
            if (nonzero)
            begin
                fl_reg <= k_reg;
                if (!found_reg)
                begin
                    top_reg   <= k_reg;
                    found_reg <= 1'b1;
                end
            end
            if (k_reg != '0)
                k_reg <= k_reg - pos_t'(1);
        end
    end

    assign busy       = st_reg != ST_IDLE;
    assign push       = st_reg == ST_PUSH && !full;
    assign desc.trits = trits_reg;
    assign desc.top   = top_reg;
    assign desc.fl    = fl_reg;
    assign desc.mov   = mov_reg;
    assign desc.zero  = !found_reg;

    a_push_in_push_state: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> st_reg == ST_IDLE)
        else $error("front hand-off did not return to idle");

endmodule

`default_nettype wire

// File: src/btc_queue.sv
// short queue of classified conversions between front and back
// depends on btc_pkg
`default_nettype none

module btc_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  btc_pkg::btc_desc_t  wr_desc,
    input  wire                 pop,
    output btc_pkg::btc_desc_t  rd_desc,
    output logic                full,
    output logic                empty
);
    import btc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    btc_desc_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign rd_desc = mem[rd_ptr_reg];
    assign full    = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = cnt_reg == '0;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// File: src/btc_back.sv
// back end: walks one classified conversion and emits its symbols,
// one per cycle, most significant first; depends on btc_pkg
`default_nettype none

module btc_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 empty,
    input  btc_pkg::btc_desc_t  head,
    output logic                pop,
    output logic                result_valid,
    output btc_pkg::btc_out_t   result
);
    import btc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LEAD  = 3'd1;
    localparam logic [2:0] ST_INT   = 3'd2;
    localparam logic [2:0] ST_POINT = 3'd3;
    localparam logic [2:0] ST_FRAC  = 3'd4;

    logic [2:0] st_reg, st_next;
    pos_t       pos_reg, pos_next;
    btc_desc_t  desc_reg;
    logic       valid_reg, valid_next;
    logic [1:0] sym_reg, sym_next;
    logic       last_reg, last_next;
    logic       has_frac;

    assign pop      = st_reg == ST_IDLE && !empty;
    assign has_frac = desc_reg.mov > desc_reg.fl;

    always_comb
    begin
        st_next    = st_reg;
        pos_next   = pos_reg;
        valid_next = 1'b0;
        sym_next   = sym_reg;
        last_next  = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    if (head.zero || head.mov > head.top)
                        st_next = ST_LEAD;
                    else
                    begin
                        st_next  = ST_INT;
                        pos_next = head.top;
                    end
                end
            end
            ST_LEAD:
            begin
                // lone zero: either the whole result or the missing integer trit
                valid_next = 1'b1;
                sym_next   = SYM_ZERO;
                last_next  = desc_reg.zero;
                st_next    = desc_reg.zero ? ST_IDLE : ST_POINT;
            end
            ST_INT:
            begin
                valid_next = 1'b1;
                sym_next   = desc_reg.trits[pos_reg];
                if (pos_reg == desc_reg.mov)
                begin
                    last_next = !has_frac;
                    st_next   = has_frac ? ST_POINT : ST_IDLE;
                end
                else
                    pos_next = pos_reg - pos_t'(1);
            end
            ST_POINT:
            begin
                valid_next = 1'b1;
                sym_next   = SYM_POINT;
                st_next    = ST_FRAC;
                pos_next   = desc_reg.mov - pos_t'(1);
            end
            ST_FRAC:
            begin
                valid_next = 1'b1;
                sym_next   = desc_reg.trits[pos_reg];
                if (pos_reg == desc_reg.fl)
                begin
                    last_next = 1'b1;
                    st_next   = ST_IDLE;
                end
                else
                    pos_next = pos_reg - pos_t'(1);
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        if (pop)
            desc_reg <= head;
    end

    assign result_valid  = valid_reg;
    assign result.symbol = sym_reg;
    assign result.last   = last_reg;

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |=> !valid_reg)
        else $error("symbol strobed right after the final symbol");

    a_point_then_trit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && sym_reg == SYM_POINT |=> valid_reg && sym_reg != SYM_POINT)
        else $error("radix point not followed by a fraction trit");

endmodule

`default_nettype wire

// File: bench/balanced_ternary_converter_tb.sv
// self-checking bench for balanced_ternary_converter: directed and random conversions
// expected symbol runs come from a scoreboard class; depends on btc_pkg and the rtl

module balanced_ternary_converter_tb;
    import btc_pkg::*;

    localparam int NT         = MAX_TRITS;
    localparam int SYMBOL_CAP = 24;

    class ternary_scoreboard;
        btc_out_t pending_symbols[$];
        int errors;
        int conversions;
        int symbols;
        int points;
        int zeros;

        // work out the symbol run of one accepted transaction
        function void note_conversion(btc_in_t op);
            logic [31:0] raw;
            int unsigned mag;
            int unsigned den;
            int unsigned sum;
            int unsigned carry;
            int          digit [NT];
            logic [1:0]  trit [NT];
            bit          neg;
            int          n;
            int          top;
            int          mov;
            int          fl;
            int          v;
            btc_out_t    run[$];
            btc_out_t    s;

            conversions++;
            raw = op.numerator;
            neg = raw[31];
            mag = neg ? 32'd0 - raw : raw;
            den = op.denominator;
            for (int i = 0; i < NT; i++)
            begin
                digit[i] = 0;
                trit[i]  = SYM_ZERO;
            end
            if (raw == 0)
            begin
                zeros++;
                s.symbol = SYM_ZERO;
                s.last   = 1'b1;
                pending_symbols.push_back(s);
                return;
            end

            n = 0;
            do
            begin
                digit[n] = mag % 3;
                mag      = mag / 3;
                n++;
            end
            while (mag > 0 && n < NT - 1);

            // add the all-ones word with carry
            carry = 0;
            for (int p = 0; p < n; p++)
            begin
                sum      = digit[p] + 1 + carry;
                digit[p] = sum % 3;
                carry    = sum / 3;
            end
            top = carry ? n : n - 1;
            if (carry)
                trit[n] = neg ? SYM_MINUS : SYM_PLUS;
            for (int p = 0; p < n; p++)
            begin
                v = digit[p] - 1;
                if (neg)
                    v = -v;
                trit[p] = (v < 0) ? SYM_MINUS : (v > 0) ? SYM_PLUS : SYM_ZERO;
            end

            mov = 0;
            while (den > 1)
            begin
                den = den / 3;
                mov++;
            end
            for (fl = 0; fl < top; fl++)
                if (trit[fl] != SYM_ZERO)
                    break;

            s.last = 1'b0;
            // no integer trit: lead with a zero
            if (mov > top)
            begin
                s.symbol = SYM_ZERO;
                run.push_back(s);
            end
            for (int p = top; p >= mov; p--)
            begin
                s.symbol = trit[p];
                run.push_back(s);
            end
            if (mov > fl)
            begin
                points++;
                s.symbol = SYM_POINT;
                run.push_back(s);
                for (int p = mov - 1; p >= fl; p--)
                begin
                    s.symbol = (p < NT) ? trit[p] : SYM_ZERO;
                    run.push_back(s);
                end
            end
            while (run.size() > SYMBOL_CAP)
                void'(run.pop_back());
            run[run.size() - 1].last = 1'b1;
            foreach (run[i])
                pending_symbols.push_back(run[i]);
        endfunction

        function void check_symbol(btc_out_t got);
            btc_out_t want;

            symbols++;
            if (pending_symbols.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: symbol %0d last %0b arrived with nothing outstanding",
                             got.symbol, got.last);
                return;
            end
            want = pending_symbols.pop_front();
            if (got.symbol !== want.symbol || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected symbol %0d last %0b, got symbol %0d last %0b",
                             want.symbol, want.last, got.symbol, got.last);
            end
        endfunction

        function void close_out();
            if (pending_symbols.size() > 0)
            begin
                errors += pending_symbols.size();
                $display("ERROR: %0d symbols never arrived", pending_symbols.size());
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    btc_in_t  operand;
    logic     busy;
    logic     result_valid;
    btc_out_t result;

    ternary_scoreboard sb;
    int idle_pct;

    balanced_ternary_converter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operand      (operand),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // results cannot be held off, so every strobe is one symbol to check
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_symbol(result);
    end

    task automatic drive_operand(input logic [31:0] num, input logic [30:0] den);
        btc_in_t op;

        op.numerator   = num;
        op.denominator = den;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        operand <= op;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_conversion(op);
    endtask

    initial
    begin
        logic [31:0] num;
        logic [30:0] den;
        int unsigned pow3;
        int unsigned low_pow;
        int          rates [3];

        rates = '{15, 65, 0};
        sb = new();
        rst_n   <= 1'b0;
        start   <= 1'b0;
        operand <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = rates[0];
        drive_operand(32'd0, 31'd1);
        drive_operand(32'd0, 31'd0);
        drive_operand(32'd1, 31'd1);
        drive_operand(-32'sd1, 31'd1);
        drive_operand(32'd2, 31'd1);
        drive_operand(-32'sd2, 31'd1);
        drive_operand(32'd13, 31'd1);
        drive_operand(32'd9, 31'd9);
        drive_operand(-32'sd27, 31'd3);
        drive_operand(32'd1, 31'd3);
        drive_operand(-32'sd1, 31'd27);
        drive_operand(32'd1, 31'd1162261467);
        drive_operand(32'd5, 31'd3);
        drive_operand(-32'sd7, 31'd9);
        drive_operand(32'd40, 31'd27);
        drive_operand(32'd4, 31'd0);
        drive_operand(32'd10, 31'd5);
        drive_operand(32'd100, 31'h7FFF_FFFF);
        drive_operand(32'h7FFF_FFFF, 31'd1);
        drive_operand(32'h8000_0001, 31'd1);
        drive_operand(32'h8000_0000, 31'd1);
        drive_operand(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        drive_operand(32'h8000_0000, 31'd1162261467);
        drive_operand(-32'sd123456789, 31'd81);

        foreach (rates[r])
        begin
            idle_pct = rates[r];
            repeat (100)
            begin
                pow3 = 1;
                repeat ($urandom_range(19)) pow3 = pow3 * 3;
                low_pow = 1;
                repeat ($urandom_range(8)) low_pow = low_pow * 3;
                case ($urandom_range(9))
                    0, 1, 2, 3: num = $urandom();
                    4, 5, 6:    num = $urandom_range(1, 300);
                    7, 8:       num = $urandom_range(1, 40) * low_pow;
                    default:    num = $urandom_range(0, 2);
                endcase
                if (!num[31] && $urandom_range(1))
                    num = 32'd0 - num;
                case ($urandom_range(9))
                    0:       den = 31'($urandom());
                    1:       den = 31'($urandom_range(0, 2));
                    default: den = 31'(pow3);
                endcase
                drive_operand(num, den);
            end
        end
        start <= 1'b0;

        while (sb.pending_symbols.size() > 0)
            @(posedge clk);
        // catch stray symbols after the last run
        repeat (60) @(posedge clk);
        sb.close_out();

        $display("covered %0d conversions (%0d zero, %0d with a radix point), %0d symbols",
                 sb.conversions, sb.zeros, sb.points, sb.symbols);
        $display("sender idle rates of 15, 65 and 0 percent; %0d failures",
                 sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
